FILE: src/rtsq_pkg.sv
package rtsq_pkg;

   localparam int PERIOD_SECONDS = 10;
   localparam int SLOTS          = PERIOD_SECONDS + 1;
   localparam int SLOT_IDX_W     = $clog2(SLOTS);
   localparam int STEP_W         = $clog2(SLOTS + 1);
   localparam int NZ_W           = $clog2(PERIOD_SECONDS + 1);
   localparam int TOT_W          = 8 + $clog2(PERIOD_SECONDS);
   localparam int QUALITY_W      = 5;
   localparam int GRADE_W        = $clog2(2 * PERIOD_SECONDS + 2) + QUALITY_W;
   localparam int RSP_TDATA_W    = 8;
   localparam int MIN_LOW_W      = 10;

   localparam logic [31:0] MS_PER_SLOT     = 32'd1000;
   localparam logic [31:0] MINUTE_MS       = 32'd60000;
   localparam logic [31:0] STALE_MS        = 32'd5000;
   localparam logic [31:0] LAST_FILL_RESET = 32'hFFFF_15A0;
   localparam logic [7:0]  COUNT_MAX       = 8'd255;
   localparam logic [MIN_LOW_W-1:0] MIN_LOW_RESET = 10'd700;

   localparam logic [1:0] FUNC_FALL = 2'd0;
   localparam logic [1:0] FUNC_RISE = 2'd1;

   typedef struct packed {
      logic [7:0] pulse;
      logic [7:0] gap;
   } slot_type;

   typedef struct packed {
      logic [NZ_W-1:0]       pulse_nz;
      logic [NZ_W-1:0]       gap_nz;
      logic [TOT_W-1:0]      total;
      logic [1:0]            empty_cnt;
      logic [SLOT_IDX_W-1:0] empty_where;
   } scan_sum_type;

   // physical slot of a logical offset from the oldest slot
   function automatic logic [SLOT_IDX_W-1:0] wrap_slot(input logic [SLOT_IDX_W-1:0] base,
                                                       input logic [SLOT_IDX_W-1:0] off);
      logic [SLOT_IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (SLOT_IDX_W+1)'(SLOTS)) begin
         sum = sum - (SLOT_IDX_W+1)'(SLOTS);
      end
      return sum[SLOT_IDX_W-1:0];
   endfunction

   function automatic logic [QUALITY_W-1:0] grade_of(input logic [NZ_W-1:0]  pulse_nz,
                                                     input logic [NZ_W-1:0]  gap_nz,
                                                     input logic [TOT_W-1:0] total);
      logic [GRADE_W-1:0] g;
      if (pulse_nz < NZ_W'(PERIOD_SECONDS)) begin
         g = GRADE_W'(pulse_nz);
      end else if (gap_nz < NZ_W'(PERIOD_SECONDS)) begin
         g = GRADE_W'(2 * PERIOD_SECONDS + 1) - GRADE_W'(gap_nz);
      end else if (total > TOT_W'(PERIOD_SECONDS)) begin
         g = GRADE_W'(PERIOD_SECONDS + 1);
      end else begin
         g = GRADE_W'(PERIOD_SECONDS);
      end
      return g[QUALITY_W-1:0];
   endfunction

endpackage

FILE: src/rtsq_scan_acc.sv
module rtsq_scan_acc (
   input  logic                           clock,
   input  logic                           clear,
   input  logic                           in_valid,
   input  rtsq_pkg::slot_type             in_slot,
   input  logic [rtsq_pkg::SLOT_IDX_W-1:0] in_lidx,
   output rtsq_pkg::scan_sum_type         sum
);
   import rtsq_pkg::*;

   scan_sum_type sum_ff;
   scan_sum_type sum_in;
   logic         empty;

   assign empty = (in_slot.pulse == 8'd0) && (in_slot.gap == 8'd0);

   always_comb begin
      sum_in = sum_ff;
      if (clear) begin
         sum_in = '0;
      end else if (in_valid) begin
         sum_in.pulse_nz = sum_ff.pulse_nz + NZ_W'(in_slot.pulse != 8'd0);
         sum_in.gap_nz   = sum_ff.gap_nz + NZ_W'(in_slot.gap != 8'd0);
         sum_in.total    = sum_ff.total + TOT_W'(in_slot.pulse);
         if (empty) begin
            // saturate at two: only "exactly one" matters
            if (sum_ff.empty_cnt != 2'd2) begin
               sum_in.empty_cnt = sum_ff.empty_cnt + 2'd1;
            end
            sum_in.empty_where = in_lidx;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

FILE: src/radio_time_signal_quality_core.sv
// Sequence: an accepted transaction first steps the window one second at a time (a slide of s
// seconds, s up to PERIOD_SECONDS+1), then scans the slots if it slid, fills and grades; a rising
// edge then reads and writes back the newest slot, and the grade goes to the output register.
// Flow: one transaction at a time; the next is accepted only after the result is loaded, which
// a result stall holds off; the single slot read port sets the scan.
// Reset: synchronous, clears window, grade and all slots (per-slot valid bits), resets timestamps.
module radio_time_signal_quality_core (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,   // [31:0] time_ms
   input  logic [1:0]                       req_tuser,   // [1:0] func
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rtsq_pkg::RSP_TDATA_W-1:0] rsp_tdata,   // [4:0] quality, rest zero
   // threshold register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rtsq_pkg::MIN_LOW_W-1:0]   csr_data     // min_low_time_ms
);
   import rtsq_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;  // step the window one second per cycle
   localparam logic [2:0] ST_SCAN  = 3'd2;  // read the graded slots
   localparam logic [2:0] ST_DRAIN = 3'd3;  // last read data into the accumulator
   localparam logic [2:0] ST_FILL  = 3'd4;  // missing-second fill and grade
   localparam logic [2:0] ST_RD    = 3'd5;  // read the newest slot
   localparam logic [2:0] ST_MOD   = 3'd6;  // count pulse and gap, write back
   localparam logic [2:0] ST_OUT   = 3'd7;  // hand the grade to the output register

   logic [2:0]            state_ff, state_in;
   logic [1:0]            func_ff, func_in;
   logic [31:0]           time_ff, time_in;
   logic [31:0]           rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [SLOT_IDX_W-1:0] base_ff, base_in;
   logic [SLOT_IDX_W-1:0] scan_ff, scan_in;
   logic [31:0]           wstart_ff, wstart_in;
   logic [31:0]           last_fall_ff, last_fall_in;
   logic [31:0]           last_fill_ff, last_fill_in;
   logic [QUALITY_W-1:0]  grade_ff, grade_in;
   logic [MIN_LOW_W-1:0]  min_low_ff;
   logic                  rsp_valid_ff;
   logic [QUALITY_W-1:0]  rsp_quality_ff;

   // slot memory: one write and one registered read per cycle
   slot_type              mem [SLOTS];
   logic [SLOTS-1:0]      valid_ff;
   logic                  wr_en;
   logic [SLOT_IDX_W-1:0] wr_addr;
   slot_type              wr_data;
   logic                  rd_en;
   logic [SLOT_IDX_W-1:0] rd_addr;
   slot_type              rd_data_ff;
   logic                  rd_valid_ff;
   logic [SLOT_IDX_W-1:0] rd_lidx_ff;

   scan_sum_type          sum;
   logic                  acc_clear;
   logic                  step_go;
   logic                  do_fill;
   logic                  out_free;
   logic                  stale;
   logic [7:0]            pulse_new;
   logic [7:0]            gap_new;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - QUALITY_W)'(0), rsp_quality_ff};

   // one more whole second behind the request time, until the window is fully replaced
   assign step_go  = (rem_ff >= MS_PER_SLOT) && (step_ff < STEP_W'(SLOTS));
   assign acc_clear = (state_ff == ST_DIV) && !step_go;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign stale    = (time_ff - wstart_ff) > STALE_MS;

   assign do_fill = (sum.empty_cnt == 2'd1) && (sum.empty_where != '0) &&
                    ((wstart_ff - last_fill_ff) >= MINUTE_MS);

   always_comb begin
      pulse_new = rd_data_ff.pulse;
      gap_new   = rd_data_ff.gap;
      if (rd_data_ff.pulse != COUNT_MAX) begin
         pulse_new = rd_data_ff.pulse + 8'd1;
      end
      if (((time_ff - last_fall_ff) >= {22'd0, min_low_ff}) && (rd_data_ff.gap != COUNT_MAX)) begin
         gap_new = rd_data_ff.gap + 8'd1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      time_in      = time_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      base_in      = base_ff;
      scan_in      = scan_ff;
      wstart_in    = wstart_ff;
      last_fall_in = last_fall_ff;
      last_fill_in = last_fill_ff;
      grade_in     = grade_ff;
      wr_en        = 1'b0;
      wr_addr      = base_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = wrap_slot(base_ff, scan_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               time_in  = req_tdata;
               // only edges slide the window; queries leave it where it is
               rem_in   = ((req_tuser == FUNC_FALL) || (req_tuser == FUNC_RISE)) ?
                          (req_tdata - wstart_ff) : 32'd0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_go) begin
               // shift by one: the oldest slot is cleared and becomes the newest
               wr_en     = 1'b1;
               wr_addr   = base_ff;
               wr_data   = '0;
               base_in   = wrap_slot(base_ff, SLOT_IDX_W'(1));
               rem_in    = rem_ff - MS_PER_SLOT;
               wstart_in = wstart_ff + MS_PER_SLOT;
               step_in   = step_ff + STEP_W'(1);
            end else begin
               if (step_ff == STEP_W'(SLOTS)) begin
                  // window fully replaced: restart it at the request time
                  wstart_in    = time_ff;
                  last_fill_in = time_ff - MINUTE_MS;
               end
               if (func_ff == FUNC_FALL) begin
                  last_fall_in = time_ff;
               end
               scan_in = '0;
               if (step_ff != '0) begin
                  state_in = ST_SCAN;
               end else if (func_ff == FUNC_RISE) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            rd_addr = wrap_slot(base_ff, scan_ff);
            scan_in = scan_ff + SLOT_IDX_W'(1);
            if (scan_ff == SLOT_IDX_W'(PERIOD_SECONDS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FILL;
         end
         ST_FILL: begin
            if (do_fill) begin
               wr_en        = 1'b1;
               wr_addr      = wrap_slot(base_ff, sum.empty_where);
               wr_data      = '{pulse: 8'd1, gap: 8'd1};
               last_fill_in = last_fill_ff + MINUTE_MS;
            end
            grade_in = grade_of(sum.pulse_nz + NZ_W'(do_fill),
                                sum.gap_nz + NZ_W'(do_fill),
                                sum.total + TOT_W'(do_fill));
            state_in = (func_ff == FUNC_RISE) ? ST_RD : ST_OUT;
         end
         ST_RD: begin
            rd_en    = 1'b1;
            rd_addr  = wrap_slot(base_ff, SLOT_IDX_W'(PERIOD_SECONDS));
            state_in = ST_MOD;
         end
         ST_MOD: begin
            wr_en    = 1'b1;
            wr_addr  = wrap_slot(base_ff, SLOT_IDX_W'(PERIOD_SECONDS));
            wr_data  = '{pulse: pulse_new, gap: gap_new};
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         base_ff      <= '0;
         scan_ff      <= '0;
         wstart_ff    <= '0;
         last_fall_ff <= '0;
         last_fill_ff <= LAST_FILL_RESET;
         grade_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         base_ff      <= base_in;
         scan_ff      <= scan_in;
         wstart_ff    <= wstart_in;
         last_fall_ff <= last_fall_in;
         last_fill_ff <= last_fill_in;
         grade_ff     <= grade_in;
      end
   end

   // hold the transaction's payload
   always_ff @(posedge clock) begin
      func_ff <= func_in;
      time_ff <= time_in;
      rem_ff  <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_low_ff <= MIN_LOW_RESET;
      end else if (csr_valid) begin
         min_low_ff <= csr_data;
      end
   end

   // slot memory; a slot never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
      rd_lidx_ff <= scan_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= (state_ff == ST_SCAN);
      end
   end

   rtsq_scan_acc u_scan_acc (
      .clock    (clock),
      .clear    (acc_clear),
      .in_valid (rd_valid_ff),
      .in_slot  (rd_data_ff),
      .in_lidx  (rd_lidx_ff),
      .sum      (sum)
   );

   // output register: drop valid once taken, load the grade when free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_quality_ff <= stale ? '0 : grade_ff;
      end
   end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

// Testbench for radio_time_signal_quality_core.
// Items go in on the request stream and quality grades come back on the result stream.
// A behavioural copy of the grading logic predicts every grade when its request is
// accepted. A monitor on the result stream compares each grade with the oldest prediction.
// The stimulus covers:
//   - directed edge cases: window boundaries, staleness, the timestamp wrap, the spare code;
//   - saturation of the slot counters;
//   - long runs of a well-formed once-per-second signal with minute markers, across
//     several thresholds, with noise, dropouts and fades mixed in.
// Both streams idle at random. One long result stall is forced so that the core backs up.
module testbench;
   import rtsq_pkg::*;

   localparam logic [1:0] FUNC_QUERY = 2'd2;
   localparam logic [1:0] FUNC_SPARE = 2'd3;   // unused code, behaves as a query
   localparam int IDLE_PCT       = 23;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int STALL_LIMIT    = 3000;
   localparam int SETTLE_CYCLES  = 40;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata  = '0;          // [31:0] time_ms
   logic [1:0]             req_tuser  = FUNC_QUERY;  // [1:0] func
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;                // [4:0] quality, rest zero
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [MIN_LOW_W-1:0]   csr_data   = '0;          // min_low_time_ms

   radio_time_signal_quality_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // grading state as the core should hold it
   logic [31:0]          win_start_ms;
   logic [31:0]          fall_ms;
   logic [31:0]          fill_ms;
   logic [QUALITY_W-1:0] grade_now;
   logic [7:0]           pulse_cnt [SLOTS];
   logic [7:0]           gap_cnt   [SLOTS];
   logic [MIN_LOW_W-1:0] min_low_ms;

   logic [QUALITY_W-1:0] quality_due [$];   // grades still owed by the core, oldest first
   logic [QUALITY_W-1:0] quality_want;

   // stimulus state
   logic [31:0] signal_ms;
   int          minute_pos;
   bit          req_idling   = 1'b1;
   bit          rsp_idling   = 1'b1;
   bit          hold_request = 1'b0;
   int          hold_left;
   int          quiet_cycles = 0;
   int          items_sent = 0, results_checked = 0, writes_done = 0, mismatches = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // shift the slots, then fill the minute marker once a minute and regrade
   function automatic void shift_slots(input int by);
      int empties, where, pulsed, gapped, total;
      for (int k = 0; k < SLOTS; k++) begin
         if (k + by < SLOTS) begin
            pulse_cnt[k] = pulse_cnt[k + by];
            gap_cnt[k]   = gap_cnt[k + by];
         end else begin
            pulse_cnt[k] = '0;
            gap_cnt[k]   = '0;
         end
      end
      empties = 0;
      where   = 0;
      for (int k = 0; k < PERIOD_SECONDS; k++) begin
         if (pulse_cnt[k] == 0 && gap_cnt[k] == 0) begin
            empties++;
            where = k;
         end
      end
      // a lone empty second, other than the oldest, is the expected missing second
      if (empties == 1 && where > 0 && (win_start_ms - fill_ms) >= MINUTE_MS) begin
         pulse_cnt[where] = 8'd1;
         gap_cnt[where]   = 8'd1;
         fill_ms          = fill_ms + MINUTE_MS;
      end
      pulsed = 0;
      gapped = 0;
      total  = 0;
      for (int k = 0; k < PERIOD_SECONDS; k++) begin
         if (pulse_cnt[k] != 0) pulsed++;
         if (gap_cnt[k] != 0) gapped++;
         total += pulse_cnt[k];
      end
      if (pulsed < PERIOD_SECONDS) grade_now = QUALITY_W'(pulsed);
      else if (gapped < PERIOD_SECONDS) grade_now = QUALITY_W'(2 * PERIOD_SECONDS + 1 - gapped);
      else if (total > PERIOD_SECONDS) grade_now = QUALITY_W'(PERIOD_SECONDS + 1);
      else grade_now = QUALITY_W'(PERIOD_SECONDS);
   endfunction

   function automatic void slide_window(input logic [31:0] stamp);
      logic [31:0] span, secs;
      span = stamp - win_start_ms;
      if (span < MS_PER_SLOT) return;
      secs = span / MS_PER_SLOT;
      if (secs < SLOTS) begin
         win_start_ms = win_start_ms + secs * MS_PER_SLOT;
         shift_slots(int'(secs));
      end else begin
         // too far ahead: restart the window at this edge
         win_start_ms = stamp;
         fill_ms      = stamp - MINUTE_MS;
         shift_slots(SLOTS);
      end
   endfunction

   function automatic logic [QUALITY_W-1:0] predict_quality(input logic [1:0]  func,
                                                            input logic [31:0] stamp);
      case (func)
         FUNC_FALL: begin
            slide_window(stamp);
            fall_ms = stamp;
         end
         FUNC_RISE: begin
            slide_window(stamp);
            if (pulse_cnt[PERIOD_SECONDS] != COUNT_MAX)
               pulse_cnt[PERIOD_SECONDS] = pulse_cnt[PERIOD_SECONDS] + 8'd1;
            if ((stamp - fall_ms) >= 32'(min_low_ms) && gap_cnt[PERIOD_SECONDS] != COUNT_MAX)
               gap_cnt[PERIOD_SECONDS] = gap_cnt[PERIOD_SECONDS] + 8'd1;
         end
         default: ;
      endcase
      return ((stamp - win_start_ms) > STALE_MS) ? '0 : grade_now;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 50) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // offer one item; keep tvalid high on return so back-to-back items need no dip
   task automatic send_item(input logic [1:0] func, input logic [31:0] stamp);
      while (req_idling && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= stamp;
      req_tuser  <= func;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      quality_due.push_back(predict_quality(func, stamp));
      items_sent++;
   endtask

   // drop tvalid and hold until every owed grade has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (quality_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_min_low(input logic [MIN_LOW_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      min_low_ms = value;
      writes_done++;
   endtask

   // One second per loop: a pulse (rise, then fall 100 or 200 ms later, up to 15 ms more) and a long low
   // until the next second. The last second of each minute carries no pulse.
   task automatic run_signal(input int seconds, input int noise_pct);
      logic [31:0] stamp;
      for (int sec = 0; sec < seconds; sec++) begin
         if (minute_pos != 59) begin
            stamp = signal_ms + $urandom_range(0, 30);
            send_item(FUNC_RISE, stamp);
            send_item(FUNC_FALL,
                      stamp + ($urandom_range(0, 1) ? 32'd200 : 32'd100) + $urandom_range(0, 15));
         end
         if ($urandom_range(0, 99) < 6) send_item(FUNC_QUERY, signal_ms + $urandom_range(0, 999));
         if ($urandom_range(0, 99) < noise_pct) begin
            case ($urandom_range(0, 4))
               0: begin   // glitch: short extra pulse inside the second
                  stamp = signal_ms + $urandom_range(300, 900);
                  send_item(FUNC_RISE, stamp);
                  send_item(FUNC_FALL, stamp + $urandom_range(1, 20));
               end
               1: send_item(2'($urandom_range(0, 3)), $urandom());
               2: signal_ms = signal_ms + MS_PER_SLOT * $urandom_range(1, 3);   // dropout
               3: begin   // long fade, then look at the grade while nothing arrives
                  signal_ms = signal_ms + $urandom_range(6000, 20000);
                  send_item(FUNC_QUERY, signal_ms);
               end
               default: send_item(FUNC_SPARE, signal_ms + $urandom_range(0, 999));
            endcase
         end
         minute_pos = (minute_pos + 1) % 60;
         signal_ms  = signal_ms + MS_PER_SLOT;
      end
   endtask

   task automatic test_directed_edges();
      send_item(FUNC_QUERY, 32'd0);             // grade straight after reset
      send_item(FUNC_SPARE, 32'hFFFF_FFFF);     // spare code, far ahead: stale
      send_item(FUNC_RISE, 32'd0);
      send_item(FUNC_FALL, 32'd300);
      send_item(FUNC_RISE, 32'd999);            // low 699 ms, still inside the first second
      send_item(FUNC_FALL, 32'd1100);
      send_item(FUNC_RISE, 32'd1800);           // low of exactly 700 ms
      send_item(FUNC_QUERY, win_start_ms + STALE_MS);          // last fresh instant
      send_item(FUNC_QUERY, win_start_ms + STALE_MS + 32'd1);  // first stale instant
      send_item(FUNC_RISE, win_start_ms + PERIOD_SECONDS * MS_PER_SLOT + 32'd5);
      send_item(FUNC_RISE, win_start_ms + SLOTS * MS_PER_SLOT);  // past the window: clear
      send_item(FUNC_FALL, 32'hFFFF_FFFF);
      send_item(FUNC_RISE, 32'h0000_0320);      // low time measured across the wrap
      send_item(FUNC_FALL, 32'h0000_0400);
      send_item(FUNC_RISE, 32'h0000_0800);      // slide by one
      send_item(FUNC_SPARE, 32'h8000_0000);
      send_item(FUNC_QUERY, 32'h0000_0800);
   endtask

   // with a zero threshold every rise also counts a gap; push both counters past 255
   task automatic test_count_saturation();
      logic [31:0] base;
      set_min_low('0);
      signal_ms = win_start_ms + 32'd20_000;
      send_item(FUNC_RISE, signal_ms);
      base = win_start_ms;
      repeat (258) send_item(FUNC_RISE, base + $urandom_range(0, 999));
      signal_ms  = base + MS_PER_SLOT;
      minute_pos = 0;
      run_signal(12, 0);   // walk the full slot out through the window
   endtask

   // threshold above every low within a minute: pulses count, gaps only after the pulseless second
   task automatic test_long_threshold();
      set_min_low(10'd1000);
      run_signal(62, 0);
   endtask

   // out-of-range threshold, with both streams running flat out
   task automatic test_threshold_ceiling();
      set_min_low(10'd1023);
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      run_signal(30, 5);
      req_idling = 1'b1;
      rsp_idling = 1'b1;
   endtask

   // random threshold, heavy noise, start just before the timestamp wraps
   task automatic test_noisy_signal();
      set_min_low(MIN_LOW_W'($urandom_range(300, 900)));
      signal_ms  = 32'hFFFF_FFFF - 32'd40_000 + $urandom_range(0, 999);
      minute_pos = $urandom_range(0, 59);
      run_signal(130, 15);
   endtask

   // stall the result stream for a long stretch while requests keep coming
   task automatic test_receiver_holdoff();
      set_min_low(MIN_LOW_RESET);
      run_signal(20, 0);
      hold_request = 1'b1;
      run_signal(105, 4);
   endtask

   // result monitor and receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (quality_due.size() == 0) begin
               report_mismatch($sformatf("result %0h with none owed", rsp_tdata));
            end else begin
               quality_want = quality_due.pop_front();
               results_checked++;
               if (rsp_tdata[QUALITY_W-1:0] !== quality_want)
                  report_mismatch($sformatf("quality %0d, predicted %0d",
                                            rsp_tdata[QUALITY_W-1:0], quality_want));
               if (rsp_tdata[RSP_TDATA_W-1:QUALITY_W] !== '0)
                  report_mismatch($sformatf("padding bits set in %0h", rsp_tdata));
            end
         end
         if (hold_request) begin
            hold_left    = HOLDOFF_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(rsp_idling && $urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // watchdog: end the run if no transaction moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d grades owed",
                     quiet_cycles, quality_due.size());
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      win_start_ms = '0;
      fall_ms      = '0;
      fill_ms      = LAST_FILL_RESET;
      grade_now    = '0;
      min_low_ms   = MIN_LOW_RESET;
      for (int k = 0; k < SLOTS; k++) begin
         pulse_cnt[k] = '0;
         gap_cnt[k]   = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_count_saturation();
      test_long_threshold();
      test_threshold_ceiling();
      test_noisy_signal();
      test_receiver_holdoff();

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d requests and checked %0d grades over %0d threshold settings,",
               items_sent, results_checked, writes_done + 1);
      $display("with counter saturation, timestamp wrap, noise and a %0d-cycle result stall",
               HOLDOFF_CYCLES);
      if (mismatches == 0 && quality_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
